### rtl/pla_pkg.sv
package pla_pkg;

    // Table geometry: first breakpoint and spacing in millimetres
    localparam int unsigned SLOTS     = 64;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned DIST_W    = 16;
    localparam int unsigned ANGLE_W   = 13;
    localparam int unsigned OFF_W     = 13;
    localparam int unsigned REM_W     = 7;
    localparam logic [DIST_W-1:0] FIRST_MM = 16'd1300;
    localparam int unsigned STEP_MM   = 100;

    // Reciprocal of 100 for the segment split: exact for offsets below 43690
    localparam int unsigned SEG_SHIFT = 19;
    localparam logic [OFF_W-1:0] SEG_RECIP = 13'd5243;

    // Reciprocal of 100 for the rounding divide: exact for values below 1.86e6
    localparam int unsigned MAG_W     = 20;
    localparam int unsigned DIV_SHIFT = 27;
    localparam int unsigned RECIP_W   = 21;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 21'd1342178;
    localparam logic [MAG_W-1:0] ROUND_HALF = 20'd50;

    // Interpolated angles always lie between the table extremes
    localparam logic [ANGLE_W-1:0] ANGLE_MIN = 13'd6200;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 13'd7100;

    // Launch angle per breakpoint in 0.01 degree; unused slots repeat the last point
    localparam logic [ANGLE_W-1:0] ANGLE_TAB [SLOTS] = '{
        13'd6200, 13'd6275, 13'd6350, 13'd6425, 13'd6500, 13'd6575, 13'd6650, 13'd6725,
        13'd6800, 13'd6875, 13'd6950, 13'd6960, 13'd6980, 13'd6800, 13'd6750, 13'd6700,
        13'd6800, 13'd6900, 13'd7000, 13'd7100,
        13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100,
        13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100,
        13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100,
        13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100,
        13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100, 13'd7100,
        13'd7100, 13'd7100, 13'd7100, 13'd7100
    };

endpackage

### rtl/piecewise_linear_angle_lookup.sv
// Distance-to-launch-angle lookup. Each item carries a distance in mm and
// returns one angle in 0.01 degree, linearly interpolated between breakpoints
// spaced 100 mm apart from 1300 mm, rounded to nearest (ties away from zero).
// Distances at or beyond either end give that end's angle; tuser flags a
// distance strictly outside the table span. One item is accepted every cycle
// while results are taken; each result passes through the segment multiply,
// synchronous table read, slope multiply and reciprocal divide stages into the
// output register. Back-pressure stalls only the stages that hold an item, so
// bubbles fill up while a result waits. The table read is a registered ROM
// access.
module piecewise_linear_angle_lookup
    import pla_pkg::*;
#(
    parameter int unsigned TABLE_POINTS = 20
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] distance_mm
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [12:0] angle_centideg, [15:13] zero
    output logic        m_axis_tuser    // [0] clamped
);

    localparam logic [DIST_W-1:0] LAST_MM =
        DIST_W'(int'(FIRST_MM) + (TABLE_POINTS - 1) * STEP_MM);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_POINTS - 1);

    // Stage valids and enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_v_reg;
    logic en1, en2, en3, en4, en_out;

    // Stage 1: range check and segment split
    logic               lo1_reg, hi1_reg, clp1_reg;
    logic [OFF_W-1:0]   off1_reg;
    logic [IDX_W-1:0]   seg1_reg;
    logic [DIST_W-1:0]  off_full;
    logic [2*OFF_W-1:0] seg_prod;

    // Stage 2: table read and remainder
    logic [ANGLE_W-1:0] a0_2_reg, a1_2_reg;
    logic [REM_W-1:0]   r2_reg;
    logic               clp2_reg;
    logic [IDX_W-1:0]   addr;
    logic [OFF_W-1:0]   rem_full;
    logic [REM_W-1:0]   rem;

    // Stage 3: slope times remainder
    logic signed [21:0] delta3_reg;
    logic [ANGLE_W-1:0] a0_3_reg;
    logic               clp3_reg;
    logic signed [ANGLE_W:0] diff;

    // Stage 4: rounded divide by 100
    logic [ANGLE_W-1:0] q4_reg;
    logic               neg4_reg;
    logic [ANGLE_W-1:0] a0_4_reg;
    logic               clp4_reg;
    logic               neg;
    logic [21:0]        mag_full;
    logic [MAG_W-1:0]   mag;
    logic [MAG_W+RECIP_W-1:0] div_prod;

    // Output register
    logic [ANGLE_W-1:0] angle_reg, angle_next;
    logic               clamped_reg;

    // Ready chain: a stage moves when it is empty or its successor moves
    assign en_out = !out_v_reg || m_axis_tready;
    assign en4    = !v4_reg || en_out;
    assign en3    = !v3_reg || en4;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)    v1_reg    <= s_axis_tvalid;
            if (en2)    v2_reg    <= v1_reg;
            if (en3)    v3_reg    <= v2_reg;
            if (en4)    v4_reg    <= v3_reg;
            if (en_out) out_v_reg <= v4_reg;
        end
    end

    // Split the offset into segment and remainder by reciprocal multiply
    always_comb
    begin
        off_full = s_axis_tdata - FIRST_MM;
        seg_prod = (2*OFF_W)'(off_full[OFF_W-1:0]) * (2*OFF_W)'(SEG_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            lo1_reg  <= (s_axis_tdata <= FIRST_MM);
            hi1_reg  <= (s_axis_tdata >= LAST_MM);
            clp1_reg <= (s_axis_tdata < FIRST_MM) || (s_axis_tdata > LAST_MM);
            off1_reg <= off_full[OFF_W-1:0];
            seg1_reg <= seg_prod[SEG_SHIFT+IDX_W-1:SEG_SHIFT];
        end
    end

    // Pick the table row; ends use the end entry with a zero remainder
    always_comb
    begin
        rem_full = off1_reg - OFF_W'(seg1_reg) * OFF_W'(STEP_MM);
        if (lo1_reg)
        begin
            addr = '0;
            rem  = '0;
        end
        else if (hi1_reg)
        begin
            addr = LAST_IDX;
            rem  = '0;
        end
        else
        begin
            addr = seg1_reg;
            rem  = rem_full[REM_W-1:0];
        end
    end

    // Synchronous table read of both segment ends
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            a0_2_reg <= ANGLE_TAB[addr];
            a1_2_reg <= ANGLE_TAB[addr + IDX_W'(1)];
            r2_reg   <= rem;
            clp2_reg <= clp1_reg;
        end
    end

    // Scale the segment slope by the remainder
    assign diff = $signed({1'b0, a1_2_reg}) - $signed({1'b0, a0_2_reg});

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            delta3_reg <= 22'($signed({1'b0, r2_reg}) * diff);
            a0_3_reg   <= a0_2_reg;
            clp3_reg   <= clp2_reg;
        end
    end

    // Round magnitude to nearest by adding half and dividing by 100
    always_comb
    begin
        neg      = delta3_reg[21];
        mag_full = neg ? 22'(-delta3_reg) : 22'(delta3_reg);
        mag      = mag_full[MAG_W-1:0] + ROUND_HALF;
        div_prod = (MAG_W+RECIP_W)'(mag) * (MAG_W+RECIP_W)'(DIV_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            q4_reg   <= div_prod[DIV_SHIFT+ANGLE_W-1:DIV_SHIFT];
            neg4_reg <= neg;
            a0_4_reg <= a0_3_reg;
            clp4_reg <= clp3_reg;
        end
    end

    // Apply the signed step to the lower breakpoint
    assign angle_next = neg4_reg ? (a0_4_reg - q4_reg) : (a0_4_reg + q4_reg);

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            angle_reg   <= angle_next;
            clamped_reg <= clp4_reg;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {3'b000, angle_reg};
    assign m_axis_tuser  = clamped_reg;

endmodule

### rtl/pla_checker.sv
module pla_checker
    import pla_pkg::*;
#(
    parameter int unsigned TABLE_POINTS = 20
)(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    localparam logic [ANGLE_W-1:0] LAST_ANGLE = ANGLE_TAB[TABLE_POINTS - 1];

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result dropped or changed while stalled");

    // Keep every angle within the table extremes and the pad bits clear
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[12:0] >= ANGLE_MIN && m_axis_tdata[12:0] <= ANGLE_MAX
            && m_axis_tdata[15:13] == 3'b000)
        else $error("angle outside table range");

    // A clamped item carries one of the end angles
    a_clamp_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[12:0] == ANGLE_TAB[0]
            || m_axis_tdata[12:0] == LAST_ANGLE)
        else $error("clamped item without an end angle");

    // Accept input whenever the output side is free
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output");

endmodule

bind piecewise_linear_angle_lookup pla_checker #(.TABLE_POINTS(TABLE_POINTS)) u_pla_checker (.*);

### verif/tb_piecewise_linear_angle_lookup.sv
module tb_piecewise_linear_angle_lookup;
    import pla_pkg::*;

    localparam int unsigned POINTS      = 20;
    localparam int          FIRST_BP_MM = 1300;
    localparam int          BP_SPACING  = 100;
    localparam int          LAST_ANGLE  = 7100;
    localparam int          HOLD_CYCLES = 200;
    localparam int          STALL_LIMIT = 2000;
    localparam int          DRAIN_WAIT  = 12;
    localparam int          RANDOM_ITEMS = 1500;

    typedef struct {
        logic [DIST_W-1:0]  distance;
        logic [ANGLE_W-1:0] angle;
        logic               clamped;
    } angle_result_t;

    // Measured launch angles per breakpoint, 0.01 degree
    localparam int MEASURED_ANGLE [20] = '{
        6200, 6275, 6350, 6425, 6500, 6575, 6650, 6725,
        6800, 6875, 6950, 6960, 6980, 6800, 6750, 6700,
        6800, 6900, 7000, 7100
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [15:0] distance_mm
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [12:0] angle_centideg, [15:13] zero
    logic        m_axis_tuser;         // [0] clamped

    logic [DIST_W-1:0] pending_distances [$];
    angle_result_t     expected_angles [$];

    int sent_count = 0;
    int accepted_count = 0;
    int results_seen = 0;
    int clamped_seen = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int hold_left = 0;
    int holds_done = 0;

    piecewise_linear_angle_lookup #(
        .TABLE_POINTS (POINTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Angle at a breakpoint slot; slots past the measured points hold the last angle
    function automatic int breakpoint_angle(int slot);
        if (slot < 20)
            return MEASURED_ANGLE[slot];
        return LAST_ANGLE;
    endfunction

    // Interpolated angle and clamp flag for one distance
    function automatic angle_result_t predict_angle(logic [DIST_W-1:0] distance);
        angle_result_t res;
        int d;
        int n;
        int last_mm;
        int off;
        int seg;
        int nxt;
        int r;
        int delta;
        int step;
        d = int'(distance);
        n = (POINTS < 2) ? 2 : ((POINTS > SLOTS) ? SLOTS : POINTS);
        last_mm = FIRST_BP_MM + (n - 1) * BP_SPACING;
        res.distance = distance;
        if (d <= FIRST_BP_MM)
        begin
            res.angle   = ANGLE_W'(breakpoint_angle(0));
            res.clamped = (d < FIRST_BP_MM);
        end
        else if (d >= last_mm)
        begin
            res.angle   = ANGLE_W'(breakpoint_angle((n - 1) % SLOTS));
            res.clamped = (d > last_mm);
        end
        else
        begin
            off   = d - FIRST_BP_MM;
            seg   = (off / BP_SPACING) % SLOTS;
            nxt   = (seg + 1) % SLOTS;
            r     = off % BP_SPACING;
            delta = r * (breakpoint_angle(nxt) - breakpoint_angle(seg));
            // round half away from zero
            if (delta >= 0)
                step = (delta + 50) / 100;
            else
                step = -((-delta + 50) / 100);
            res.angle   = ANGLE_W'(breakpoint_angle(seg) + step);
            res.clamped = 1'b0;
        end
        return res;
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int draw_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Random distance, weighted towards the table span and its breakpoints
    function automatic logic [DIST_W-1:0] random_distance();
        int p;
        int v;
        p = $urandom_range(0, 99);
        if (p < 55)
            v = $urandom_range(1301, 3199);
        else if (p < 72)
            v = FIRST_BP_MM + BP_SPACING * $urandom_range(0, 19) + $urandom_range(0, 4) - 2;
        else if (p < 80)
            v = $urandom_range(1200, 1400);
        else if (p < 88)
            v = $urandom_range(3100, 3300);
        else
            v = $urandom_range(0, 65535);
        return DIST_W'(v);
    endfunction

    // Offer pending items; log the expected angle of each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_angles.push_back(predict_angle(s_axis_tdata));
                accepted_count <= accepted_count + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    send_gap      <= send_gap - 1;
                end
                else if (pending_distances.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_distances.pop_front();
                    sent_count    <= sent_count + 1;
                    // no idling in the first stretch of every window of 300 items
                    send_gap      <= ((sent_count % 300) < 60) ? 0 : draw_gap();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Drive ready: random stalls, burst windows and two long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_stall    <= 0;
            hold_left     <= 0;
            holds_done    <= 0;
        end
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if ((holds_done == 0 && results_seen >= 100) ||
                 (holds_done == 1 && results_seen >= 800))
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            holds_done    <= holds_done + 1;
        end
        else if (recv_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            recv_stall    <= recv_stall - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ((results_seen % 300) >= 150 && $urandom_range(0, 2) == 0)
                recv_stall <= draw_gap();
        end
    end

    // Check each accepted result against the oldest expected angle
    always @(posedge clk)
    begin
        angle_result_t want;
        int errs;
        errs = 0;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen <= results_seen + 1;
            if (expected_angles.size() == 0)
            begin
                $display("%0t: unexpected result: angle %0d clamped %0b",
                         $time, m_axis_tdata[ANGLE_W-1:0], m_axis_tuser);
                errs = errs + 1;
            end
            else
            begin
                want = expected_angles.pop_front();
                if (want.clamped)
                    clamped_seen <= clamped_seen + 1;
                if (m_axis_tdata[ANGLE_W-1:0] !== want.angle)
                begin
                    $display("%0t: angle for %0d mm: expected %0d, actual %0d",
                             $time, want.distance, want.angle, m_axis_tdata[ANGLE_W-1:0]);
                    errs = errs + 1;
                end
                if (m_axis_tdata[15:ANGLE_W] !== '0)
                begin
                    $display("%0t: pad bits for %0d mm: expected 0, actual %0b",
                             $time, want.distance, m_axis_tdata[15:ANGLE_W]);
                    errs = errs + 1;
                end
                if (m_axis_tuser !== want.clamped)
                begin
                    $display("%0t: clamped for %0d mm: expected %0b, actual %0b",
                             $time, want.distance, want.clamped, m_axis_tuser);
                    errs = errs + 1;
                end
            end
        end
        if (errs != 0)
            mismatches <= mismatches + errs;
    end

    // Count cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Load stimulus, then wait for the pipeline to empty and report
    initial
    begin
        // ends, clamp boundaries, rounding ties both ways, wide offsets
        pending_distances.push_back(16'd0);
        pending_distances.push_back(16'd65535);
        pending_distances.push_back(16'd1);
        pending_distances.push_back(16'd1299);
        pending_distances.push_back(16'd1300);
        pending_distances.push_back(16'd1301);
        pending_distances.push_back(16'd1302);
        pending_distances.push_back(16'd1350);
        pending_distances.push_back(16'd1399);
        pending_distances.push_back(16'd1400);
        pending_distances.push_back(16'd2305);
        pending_distances.push_back(16'd2550);
        pending_distances.push_back(16'd2601);
        pending_distances.push_back(16'd2699);
        pending_distances.push_back(16'd2750);
        pending_distances.push_back(16'd2999);
        pending_distances.push_back(16'd3199);
        pending_distances.push_back(16'd3200);
        pending_distances.push_back(16'd3201);
        pending_distances.push_back(16'd3300);
        pending_distances.push_back(16'd32767);
        pending_distances.push_back(16'd32768);
        pending_distances.push_back(16'd43690);
        pending_distances.push_back(16'd44990);
        repeat (RANDOM_ITEMS)
            pending_distances.push_back(random_distance());

        wait (rst_n === 1'b1);
        // sample between edges so the driver and monitor updates have settled
        while ((pending_distances.size() != 0 || s_axis_tvalid ||
                expected_angles.size() != 0) && idle_cycles < STALL_LIMIT)
            @(negedge clk);

        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_angles.size());
            $display("[piecewise_linear_angle_lookup] ERROR");
        end
        else
        begin
            repeat (DRAIN_WAIT) @(posedge clk);
            $display("Looked up %0d distances, %0d angles checked (%0d clamped), %0d mismatches;",
                     accepted_count, results_seen, clamped_seen, mismatches);
            $display("both sides idled at random and output held off %0d times.", holds_done);
            if (mismatches == 0 && expected_angles.size() == 0)
                $display("[piecewise_linear_angle_lookup] OK");
            else
                $display("[piecewise_linear_angle_lookup] ERROR");
        end
        $finish;
    end

endmodule
